// ===== design/sid_pkg.sv =====
// Shared constants and types for the signed integer to decimal text core.
`timescale 1ns / 1ps
`default_nettype none
package sid_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam int CharWidth = 6;

  localparam logic [CharWidth-1:0] CHAR_ZERO  = 6'd48;
  localparam logic [CharWidth-1:0] CHAR_MINUS = 6'd45;
  localparam logic [CharWidth-1:0] CHAR_NINE  = 6'd57;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_CONV,
    BK_SKIP,
    BK_SIGN,
    BK_DIGIT
  } sid_back_state_t;

endpackage
`default_nettype wire

// ===== design/sid_if.sv =====
// Valid/ready channel interfaces for the input value and the output characters.
`timescale 1ns / 1ps
`default_nettype none
interface sid_in_if #(
  parameter int VALUE_WIDTH = sid_pkg::VALUE_WIDTH_DEF
);
  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface sid_out_if;
  logic                           valid;
  logic                           ready;
  logic [sid_pkg::CharWidth-1:0]  character;
  logic                           last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface
`default_nettype wire

// ===== design/sid_front.sv =====
// Front end: accepts a value and splits it into sign and unsigned magnitude.
`timescale 1ns / 1ps
`default_nettype none
module sid_front #(
  parameter int VALUE_WIDTH = sid_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [VALUE_WIDTH-1:0] in_value,
  input  wire logic                   q_full,
  output logic                        q_push,
  output logic [VALUE_WIDTH:0]        q_data
);

  logic                   neg;
  logic [VALUE_WIDTH-1:0] mag;

  // Most negative value wraps to 2^(W-1), which is its true magnitude unsigned.
  assign neg = in_value[VALUE_WIDTH-1];
  assign mag = neg ? (~in_value + {{(VALUE_WIDTH-1){1'b0}}, 1'b1}) : in_value;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;
  assign q_data   = {neg, mag};

endmodule
`default_nettype wire

// ===== design/sid_queue.sv =====
// Small FIFO between the front end and the conversion back end.
`timescale 1ns / 1ps
`default_nettype none
module sid_queue #(
  parameter int WIDTH = sid_pkg::VALUE_WIDTH_DEF + 1,
  parameter int DEPTH = sid_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic                  not_empty,
  output logic [WIDTH-1:0]      pop_data
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PtrW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]  count_r, count_nxt;

  assign full      = (count_r == CntW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_r + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_r + PtrW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CntW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

// ===== design/sid_back.sv =====
// Back end: shift-add-3 binary to BCD, leading-zero skip, character output.
`timescale 1ns / 1ps
`default_nettype none
module sid_back #(
  parameter int VALUE_WIDTH = sid_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          q_not_empty,
  input  wire logic [VALUE_WIDTH:0]          q_data,
  output logic                               q_pop,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [sid_pkg::CharWidth-1:0]      out_character,
  output logic                               out_last
);

  // decimal digits of 2^W: floor(W*log10(2)) + 1
  localparam int NumDigits = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int BcdW      = 4 * NumDigits;
  localparam int StepW     = $clog2(VALUE_WIDTH + 1);
  localparam int DigW      = $clog2(NumDigits + 1);

  sid_pkg::sid_back_state_t state_r, state_nxt;

  logic [VALUE_WIDTH-1:0]          mag_r, mag_nxt;
  logic [BcdW-1:0]                 bcd_r, bcd_nxt;
  logic [BcdW-1:0]                 bcd_adj;
  logic                            neg_r, neg_nxt;
  logic [StepW-1:0]                step_r, step_nxt;
  logic [DigW-1:0]                 dig_r, dig_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [sid_pkg::CharWidth-1:0]   out_char_r, out_char_nxt;
  logic                            out_last_r, out_last_nxt;
  logic                            out_free;
  logic [3:0]                      top_digit;

  assign out_free  = !out_valid_r || out_ready;
  assign top_digit = bcd_r[BcdW-1 -: 4];

  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      bcd_adj[4*i +: 4] = (bcd_r[4*i +: 4] >= 4'd5) ? bcd_r[4*i +: 4] + 4'd3
                                                     : bcd_r[4*i +: 4];
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sid_pkg::BK_IDLE: begin
        if (q_not_empty) state_nxt = sid_pkg::BK_CONV;
      end
      sid_pkg::BK_CONV: begin
        if (step_r == StepW'(1)) state_nxt = sid_pkg::BK_SKIP;
      end
      sid_pkg::BK_SKIP: begin
        if (!(dig_r > DigW'(1) && top_digit == 4'd0)) begin
          state_nxt = neg_r ? sid_pkg::BK_SIGN : sid_pkg::BK_DIGIT;
        end
      end
      sid_pkg::BK_SIGN: begin
        if (out_free) state_nxt = sid_pkg::BK_DIGIT;
      end
      sid_pkg::BK_DIGIT: begin
        if (out_free && dig_r == DigW'(1)) state_nxt = sid_pkg::BK_IDLE;
      end
      default: state_nxt = sid_pkg::BK_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    q_pop         = 1'b0;
    mag_nxt       = mag_r;
    bcd_nxt       = bcd_r;
    neg_nxt       = neg_r;
    step_nxt      = step_r;
    dig_nxt       = dig_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    case (state_r)
      sid_pkg::BK_IDLE: begin
        if (q_not_empty) begin
          q_pop    = 1'b1;
          neg_nxt  = q_data[VALUE_WIDTH];
          mag_nxt  = q_data[VALUE_WIDTH-1:0];
          bcd_nxt  = '0;
          step_nxt = StepW'(VALUE_WIDTH);
          dig_nxt  = DigW'(NumDigits);
        end
      end
      sid_pkg::BK_CONV: begin
        bcd_nxt  = {bcd_adj[BcdW-2:0], mag_r[VALUE_WIDTH-1]};
        mag_nxt  = {mag_r[VALUE_WIDTH-2:0], 1'b0};
        step_nxt = step_r - StepW'(1);
      end
      sid_pkg::BK_SKIP: begin
        // drop leading zeros; a zero value keeps its final digit
        if (dig_r > DigW'(1) && top_digit == 4'd0) begin
          bcd_nxt = {bcd_r[BcdW-5:0], 4'd0};
          dig_nxt = dig_r - DigW'(1);
        end
      end
      sid_pkg::BK_SIGN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = sid_pkg::CHAR_MINUS;
          out_last_nxt  = 1'b0;
        end
      end
      sid_pkg::BK_DIGIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = sid_pkg::CHAR_ZERO + {2'b00, top_digit};
          out_last_nxt  = (dig_r == DigW'(1));
          bcd_nxt       = {bcd_r[BcdW-5:0], 4'd0};
          dig_nxt       = dig_r - DigW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sid_pkg::BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r      <= mag_nxt;
    bcd_r      <= bcd_nxt;
    neg_r      <= neg_nxt;
    step_r     <= step_nxt;
    dig_r      <= dig_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_character = out_char_r;
  assign out_last      = out_last_r;

endmodule
`default_nettype wire

// ===== design/signed_int_to_decimal_ascii_core.sv =====
// Top level: signed integer in, decimal ASCII characters out.
//
//  channel | dir | payload                    | handshake
//  in_ch   | in  | value [VALUE_WIDTH-1:0]    | valid/ready
//  out_ch  | out | character [5:0], last      | valid/ready
//
// In the back end, one item passes through the one-bit-per-cycle shift-add-3 loop,
// the leading-zero skip, a minus sign for a negative value and then its digit
// characters; the next item is popped the cycle after the last character.
// Up to QUEUE_DEPTH items wait in the queue while the back end is busy.
// Reset is synchronous, active low, and clears the queue and the back-end FSM.
// A stalled output holds its character; the back end waits and the queue fills.
`timescale 1ns / 1ps
`default_nettype none
module signed_int_to_decimal_ascii_core #(
  parameter int VALUE_WIDTH = sid_pkg::VALUE_WIDTH_DEF,
  parameter int QUEUE_DEPTH = sid_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  sid_in_if.sink    in_ch,
  sid_out_if.source out_ch
);

  logic                   q_full;
  logic                   q_push;
  logic [VALUE_WIDTH:0]   q_wdata;
  logic                   q_pop;
  logic                   q_not_empty;
  logic [VALUE_WIDTH:0]   q_rdata;

  sid_front #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_front (
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_value (in_ch.value),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_wdata)
  );

  sid_queue #(
    .WIDTH(VALUE_WIDTH + 1),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_data  (q_rdata)
  );

  sid_back #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_not_empty   (q_not_empty),
    .q_data        (q_rdata),
    .q_pop         (q_pop),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_character (out_ch.character),
    .out_last      (out_ch.last)
  );

endmodule
`default_nettype wire

// ===== design/sid_checker.sv =====
// Port-level assertions for the decimal text core, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module sid_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [sid_pkg::CharWidth-1:0] out_character,
  input wire logic                          out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output item dropped while stalled");

  a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_character == sid_pkg::CHAR_MINUS ||
                   (out_character >= sid_pkg::CHAR_ZERO &&
                    out_character <= sid_pkg::CHAR_NINE)))
    else $error("illegal output character");

  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_character == sid_pkg::CHAR_MINUS |-> !out_last)
    else $error("minus sign marked as last");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind signed_int_to_decimal_ascii_core sid_checker u_sid_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_character (out_ch.character),
  .out_last      (out_ch.last)
);
`default_nettype wire
